// ===== rtl/mme_pkg.sv =====
// Shared constants, types and helpers of the matrix multiply engine.
package mme_pkg;

   localparam int MAX_DIM   = 8;
   localparam int DIM_W     = 4;
   localparam int CNT_W     = 3;
   localparam int ADDR_W    = 6;
   localparam int DEPTH     = MAX_DIM * MAX_DIM;
   localparam int DATA_W    = 16;
   localparam int PROD_W    = 2 * DATA_W;
   localparam int ACC_W     = PROD_W + CNT_W;
   localparam int OPC_W     = 2;
   localparam int CSR_IDX_W = 2;

   localparam logic [OPC_W-1:0] OP_LOAD_A  = 2'd0;
   localparam logic [OPC_W-1:0] OP_LOAD_B  = 2'd1;
   localparam logic [OPC_W-1:0] OP_COMPUTE = 2'd2;

   localparam logic [CSR_IDX_W-1:0] REG_ROW_COUNT   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_COL_COUNT   = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_INNER_COUNT = 2'd2;

   // Commands from the sequencer to the datapath.
   typedef struct packed {
      logic              rd_en;
      logic              first;
      logic [ADDR_W-1:0] addr_a;
      logic [ADDR_W-1:0] addr_b;
      logic              emit;
      logic [CNT_W-1:0]  row;
      logic [CNT_W-1:0]  col;
      logic              last;
   } cmd_type;

   // Status from the datapath back to the sequencer.
   typedef struct packed {
      logic pipe_empty;
      logic out_free;
   } status_type;

   // A size of zero acts as one, anything above the maximum as the maximum.
   function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v);
      logic [DIM_W-1:0] r;
      r = v;
      if (v == '0) begin
         r = DIM_W'(1);
      end else if (v > DIM_W'(MAX_DIM)) begin
         r = DIM_W'(MAX_DIM);
      end
      return r;
   endfunction

endpackage

// ===== rtl/mme_if.sv =====
// Channel interfaces of the matrix multiply engine: request, response and register write.
interface mme_req_if;
   logic                                valid;
   logic                                ready;
   logic        [mme_pkg::OPC_W-1:0]    opcode;
   logic        [mme_pkg::ADDR_W-1:0]   element_index;
   logic signed [mme_pkg::DATA_W-1:0]   element_value;

   modport source (output valid, output opcode, output element_index, output element_value,
                   input ready);
   modport sink   (input valid, input opcode, input element_index, input element_value,
                   output ready);
endinterface

interface mme_rsp_if;
   logic                                valid;
   logic                                ready;
   logic signed [mme_pkg::DATA_W-1:0]   product_value;
   logic        [mme_pkg::CNT_W-1:0]    product_row;
   logic        [mme_pkg::CNT_W-1:0]    product_col;
   logic                                saturated;
   logic                                last_of_run;

   modport source (output valid, output product_value, output product_row,
                   output product_col, output saturated, output last_of_run, input ready);
   modport sink   (input valid, input product_value, input product_row,
                   input product_col, input saturated, input last_of_run, output ready);
endinterface

interface mme_csr_if;
   logic                                valid;
   logic                                ready;
   logic        [mme_pkg::CSR_IDX_W-1:0] index;
   logic        [mme_pkg::DIM_W-1:0]     data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== rtl/mme_ctrl.sv =====
// Sequencer of the matrix multiply engine: size registers and the row, column, inner walk.
module mme_ctrl (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   input  logic [mme_pkg::OPC_W-1:0]         req_opcode,
   input  logic                              csr_valid,
   input  logic [mme_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [mme_pkg::DIM_W-1:0]         csr_data,
   output logic                              idle,
   output mme_pkg::cmd_type                  cmd,
   input  mme_pkg::status_type               status
);
   import mme_pkg::*;

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_ISSUE = 2'd1;
   localparam logic [1:0] ST_WAIT  = 2'd2;

   logic [1:0]        state_ff, state_in;
   logic [DIM_W-1:0]  row_count_ff, row_count_in;
   logic [DIM_W-1:0]  col_count_ff, col_count_in;
   logic [DIM_W-1:0]  inner_count_ff, inner_count_in;
   logic [DIM_W-1:0]  n_ff, n_in;
   logic [DIM_W-1:0]  k_ff, k_in;
   logic [CNT_W-1:0]  m_last_ff, m_last_in;
   logic [CNT_W-1:0]  n_last_ff, n_last_in;
   logic [CNT_W-1:0]  k_last_ff, k_last_in;
   logic [CNT_W-1:0]  i_ff, i_in;
   logic [CNT_W-1:0]  j_ff, j_in;
   logic [CNT_W-1:0]  t_ff, t_in;
   logic [ADDR_W-1:0] a_base_ff, a_base_in;
   logic [ADDR_W-1:0] a_addr_ff, a_addr_in;
   logic [ADDR_W-1:0] b_addr_ff, b_addr_in;
   logic [DIM_W-1:0]  m_clamp, n_clamp, k_clamp;
   logic              elem_last;

   assign idle    = (state_ff == ST_IDLE);
   assign m_clamp = clamp_dim(row_count_ff);
   assign n_clamp = clamp_dim(col_count_ff);
   assign k_clamp = clamp_dim(inner_count_ff);
   assign elem_last = (i_ff == m_last_ff) && (j_ff == n_last_ff);

   always_comb begin
      row_count_in   = row_count_ff;
      col_count_in   = col_count_ff;
      inner_count_in = inner_count_ff;
      if (csr_valid) begin
         unique case (csr_index)
            REG_ROW_COUNT:   row_count_in   = csr_data;
            REG_COL_COUNT:   col_count_in   = csr_data;
            REG_INNER_COUNT: inner_count_in = csr_data;
            default: ;
         endcase
      end
   end

   always_comb begin
      state_in  = state_ff;
      n_in      = n_ff;
      k_in      = k_ff;
      m_last_in = m_last_ff;
      n_last_in = n_last_ff;
      k_last_in = k_last_ff;
      i_in      = i_ff;
      j_in      = j_ff;
      t_in      = t_ff;
      a_base_in = a_base_ff;
      a_addr_in = a_addr_ff;
      b_addr_in = b_addr_ff;
      cmd        = '0;
      cmd.addr_a = a_addr_ff;
      cmd.addr_b = b_addr_ff;
      cmd.first  = (t_ff == '0);
      cmd.row    = i_ff;
      cmd.col    = j_ff;
      cmd.last   = elem_last;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid && req_opcode == OP_COMPUTE) begin
               n_in      = n_clamp;
               k_in      = k_clamp;
               m_last_in = CNT_W'(m_clamp - DIM_W'(1));
               n_last_in = CNT_W'(n_clamp - DIM_W'(1));
               k_last_in = CNT_W'(k_clamp - DIM_W'(1));
               i_in      = '0;
               j_in      = '0;
               t_in      = '0;
               a_base_in = '0;
               a_addr_in = '0;
               b_addr_in = '0;
               state_in  = ST_ISSUE;
            end
         end
         ST_ISSUE: begin
            cmd.rd_en = 1'b1;
            if (t_ff == k_last_ff) begin
               t_in     = '0;
               state_in = ST_WAIT;
            end else begin
               t_in      = t_ff + CNT_W'(1);
               a_addr_in = a_addr_ff + ADDR_W'(1);
               b_addr_in = b_addr_ff + ADDR_W'(n_ff);
            end
         end
         ST_WAIT: begin
            // The sum is final once the read and multiply stages have drained.
            if (status.pipe_empty && status.out_free) begin
               cmd.emit = 1'b1;
               if (elem_last) begin
                  state_in = ST_IDLE;
               end else if (j_ff == n_last_ff) begin
                  j_in      = '0;
                  i_in      = i_ff + CNT_W'(1);
                  a_base_in = a_base_ff + ADDR_W'(k_ff);
                  a_addr_in = a_base_ff + ADDR_W'(k_ff);
                  b_addr_in = '0;
                  state_in  = ST_ISSUE;
               end else begin
                  j_in      = j_ff + CNT_W'(1);
                  a_addr_in = a_base_ff;
                  b_addr_in = ADDR_W'(j_ff + CNT_W'(1));
                  state_in  = ST_ISSUE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         row_count_ff   <= DIM_W'(MAX_DIM);
         col_count_ff   <= DIM_W'(MAX_DIM);
         inner_count_ff <= DIM_W'(MAX_DIM);
      end else begin
         state_ff       <= state_in;
         row_count_ff   <= row_count_in;
         col_count_ff   <= col_count_in;
         inner_count_ff <= inner_count_in;
      end
   end

   always_ff @(posedge clock) begin
      n_ff      <= n_in;
      k_ff      <= k_in;
      m_last_ff <= m_last_in;
      n_last_ff <= n_last_in;
      k_last_ff <= k_last_in;
      i_ff      <= i_in;
      j_ff      <= j_in;
      t_ff      <= t_in;
      a_base_ff <= a_base_in;
      a_addr_ff <= a_addr_in;
      b_addr_ff <= b_addr_in;
   end

endmodule

// ===== rtl/mme_datapath.sv =====
// Datapath of the matrix multiply engine: element stores, multiplier, accumulator, result register.
module mme_datapath (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              load_accept,
   input  logic [mme_pkg::OPC_W-1:0]         load_opcode,
   input  logic [mme_pkg::ADDR_W-1:0]        load_index,
   input  logic signed [mme_pkg::DATA_W-1:0] load_value,
   input  mme_pkg::cmd_type                  cmd,
   output mme_pkg::status_type               status,
   output logic                              out_valid,
   input  logic                              out_ready,
   output logic signed [mme_pkg::DATA_W-1:0] out_value,
   output logic [mme_pkg::CNT_W-1:0]         out_row,
   output logic [mme_pkg::CNT_W-1:0]         out_col,
   output logic                              out_saturated,
   output logic                              out_last
);
   import mme_pkg::*;

   localparam int Q_W = ACC_W - 8;

   logic signed [DATA_W-1:0] store_a_ff [DEPTH];
   logic signed [DATA_W-1:0] store_b_ff [DEPTH];
   logic signed [DATA_W-1:0] rd_a_ff, rd_b_ff;
   logic                     rd_valid_ff, rd_valid_in;
   logic                     rd_first_ff;
   logic signed [PROD_W-1:0] prod_ff, prod_in;
   logic                     prod_valid_ff, prod_valid_in;
   logic                     prod_first_ff;
   logic signed [ACC_W-1:0]  acc_ff, acc_in;
   logic signed [Q_W-1:0]    q;
   logic                     sat_hi, sat_lo;
   logic signed [DATA_W-1:0] sat_value;
   logic                     out_valid_ff, out_valid_in;
   logic signed [DATA_W-1:0] out_value_ff, out_value_in;
   logic [CNT_W-1:0]         out_row_ff, out_row_in;
   logic [CNT_W-1:0]         out_col_ff, out_col_in;
   logic                     out_sat_ff, out_sat_in;
   logic                     out_last_ff, out_last_in;

   // Stores are written by load beats and read one entry each per issue cycle.
   always_ff @(posedge clock) begin
      if (load_accept && load_opcode == OP_LOAD_A) begin
         store_a_ff[load_index] <= load_value;
      end
      if (load_accept && load_opcode == OP_LOAD_B) begin
         store_b_ff[load_index] <= load_value;
      end
      if (cmd.rd_en) begin
         rd_a_ff <= store_a_ff[cmd.addr_a];
         rd_b_ff <= store_b_ff[cmd.addr_b];
      end
   end

   assign rd_valid_in   = cmd.rd_en;
   assign prod_valid_in = rd_valid_ff;
   assign prod_in       = rd_a_ff * rd_b_ff;

   always_comb begin
      acc_in = acc_ff;
      if (prod_valid_ff) begin
         if (prod_first_ff) begin
            acc_in = ACC_W'(prod_ff);
         end else begin
            acc_in = acc_ff + ACC_W'(prod_ff);
         end
      end
   end

   // An arithmetic shift by 8 rounds toward minus infinity.
   assign q      = acc_ff[ACC_W-1:8];
   assign sat_hi = !q[Q_W-1] && (q[Q_W-2:DATA_W-1] != '0);
   assign sat_lo =  q[Q_W-1] && (q[Q_W-2:DATA_W-1] != '1);

   always_comb begin
      if (sat_hi) begin
         sat_value = {1'b0, {(DATA_W-1){1'b1}}};
      end else if (sat_lo) begin
         sat_value = {1'b1, {(DATA_W-1){1'b0}}};
      end else begin
         sat_value = q[DATA_W-1:0];
      end
   end

   always_comb begin
      out_valid_in = out_valid_ff && !out_ready;
      out_value_in = out_value_ff;
      out_row_in   = out_row_ff;
      out_col_in   = out_col_ff;
      out_sat_in   = out_sat_ff;
      out_last_in  = out_last_ff;
      if (cmd.emit) begin
         out_valid_in = 1'b1;
         out_value_in = sat_value;
         out_row_in   = cmd.row;
         out_col_in   = cmd.col;
         out_sat_in   = sat_hi || sat_lo;
         out_last_in  = cmd.last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_valid_ff   <= 1'b0;
         prod_valid_ff <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         rd_valid_ff   <= rd_valid_in;
         prod_valid_ff <= prod_valid_in;
         out_valid_ff  <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rd_first_ff   <= cmd.first;
      prod_ff       <= prod_in;
      prod_first_ff <= rd_first_ff;
      acc_ff        <= acc_in;
      out_value_ff  <= out_value_in;
      out_row_ff    <= out_row_in;
      out_col_ff    <= out_col_in;
      out_sat_ff    <= out_sat_in;
      out_last_ff   <= out_last_in;
   end

   assign status.pipe_empty = !rd_valid_ff && !prod_valid_ff;
   assign status.out_free   = !out_valid_ff || out_ready;

   assign out_valid     = out_valid_ff;
   assign out_value     = out_value_ff;
   assign out_row       = out_row_ff;
   assign out_col       = out_col_ff;
   assign out_saturated = out_sat_ff;
   assign out_last      = out_last_ff;

endmodule

// ===== rtl/matrix_multiply_engine.sv =====
// Top level of the matrix multiply engine: sequencer and datapath joined to the channels.
//
// Load beats on req_if (opcode load A or load B) write one signed Q8.8 element
// into a 64-entry store at the given row-major index and return nothing. A
// compute beat walks the M x N product in row-major order and returns one
// rsp_if beat per element, the final one flagged last_of_run.
// Each element reads K pairs of entries, one pair per cycle, through a read
// register and a registered 16x16 multiplier into a 35-bit accumulator.
// req_if.ready is high only while no compute is in progress.
// Sizes are written on csr_if (index 0 rows M, 1 columns N, 2 inner K), which
// is always ready; write them only while the engine is idle.
// Reset sets all sizes to 8 and empties the pipeline; the stores keep no reset
// value and each entry must be loaded before a compute reads it.
// A stalled receiver holds the result beat in the output register and the walk
// waits until that register is free, so nothing is dropped.
module matrix_multiply_engine (
   input logic      clock,
   input logic      reset,
   mme_req_if.sink  req_if,
   mme_rsp_if.source rsp_if,
   mme_csr_if.sink  csr_if
);
   import mme_pkg::*;

   cmd_type    cmd;
   status_type status;
   logic       idle;
   logic       req_accept;

   assign req_if.ready = idle;
   assign csr_if.ready = 1'b1;
   assign req_accept   = req_if.valid && idle;

   mme_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_if.valid),
      .req_opcode (req_if.opcode),
      .csr_valid  (csr_if.valid),
      .csr_index  (csr_if.index),
      .csr_data   (csr_if.data),
      .idle       (idle),
      .cmd        (cmd),
      .status     (status)
   );

   mme_datapath u_datapath (
      .clock         (clock),
      .reset         (reset),
      .load_accept   (req_accept),
      .load_opcode   (req_if.opcode),
      .load_index    (req_if.element_index),
      .load_value    (req_if.element_value),
      .cmd           (cmd),
      .status        (status),
      .out_valid     (rsp_if.valid),
      .out_ready     (rsp_if.ready),
      .out_value     (rsp_if.product_value),
      .out_row       (rsp_if.product_row),
      .out_col       (rsp_if.product_col),
      .out_saturated (rsp_if.saturated),
      .out_last      (rsp_if.last_of_run)
   );

endmodule

// ===== tb/matrix_multiply_engine_tb.sv =====
`timescale 1ns / 100ps
// Testbench of the matrix multiply engine: randomized loads and computes checked by a scoreboard.
module matrix_multiply_engine_tb;
   import mme_pkg::*;

   localparam logic [CSR_IDX_W-1:0] REG_UNUSED = 2'd3;
   localparam logic [OPC_W-1:0]     OP_NONE    = 2'd3;
   localparam int IDLE_GUARD     = 24;
   localparam int WATCHDOG_LIMIT = 4000;
   localparam int RANDOM_ITEMS   = 350;

   typedef struct {
      logic signed [DATA_W-1:0] value;
      logic [CNT_W-1:0]         row;
      logic [CNT_W-1:0]         col;
      logic                     sat;
      logic                     last;
   } product_type;

   class product_tracker_type;
      logic signed [DATA_W-1:0] store_a [DEPTH];
      logic signed [DATA_W-1:0] store_b [DEPTH];
      bit                       written_a [DEPTH];
      bit                       written_b [DEPTH];
      logic [DIM_W-1:0]         size_reg [3];
      product_type              pending [$];
      int errors;
      int loads;
      int computes;
      int checked;
      int saturations;

      function new();
         size_reg    = '{4'd8, 4'd8, 4'd8};
         errors      = 0;
         loads       = 0;
         computes    = 0;
         checked     = 0;
         saturations = 0;
      endfunction

      function void write_size(logic [CSR_IDX_W-1:0] index, logic [DIM_W-1:0] data);
         if (index <= REG_INNER_COUNT) begin
            size_reg[index] = data;
         end
      endfunction

      function int used_dim(logic [CSR_IDX_W-1:0] index);
         int v;
         v = size_reg[index];
         if (v == 0) begin
            v = 1;
         end else if (v > MAX_DIM) begin
            v = MAX_DIM;
         end
         return v;
      endfunction

      function void note_request(logic [OPC_W-1:0] opcode, logic [ADDR_W-1:0] index,
                                 logic signed [DATA_W-1:0] value);
         int          m;
         int          n;
         int          k;
         longint      acc;
         longint      q;
         product_type p;
         case (opcode)
            OP_LOAD_A: begin
               store_a[index]   = value;
               written_a[index] = 1'b1;
               loads++;
            end
            OP_LOAD_B: begin
               store_b[index]   = value;
               written_b[index] = 1'b1;
               loads++;
            end
            OP_COMPUTE: begin
               m = used_dim(REG_ROW_COUNT);
               n = used_dim(REG_COL_COUNT);
               k = used_dim(REG_INNER_COUNT);
               computes++;
               for (int i = 0; i < m; i++) begin
                  for (int j = 0; j < n; j++) begin
                     acc = 0;
                     for (int t = 0; t < k; t++) begin
                        acc += longint'(store_a[(i * k + t) % DEPTH]) *
                               longint'(store_b[(t * n + j) % DEPTH]);
                     end
                     // The arithmetic shift rounds toward minus infinity.
                     q     = acc >>> 8;
                     p.sat = (q > 32767) || (q < -32768);
                     if (q > 32767) begin
                        q = 32767;
                     end else if (q < -32768) begin
                        q = -32768;
                     end
                     p.value = q[DATA_W-1:0];
                     p.row   = CNT_W'(i);
                     p.col   = CNT_W'(j);
                     p.last  = (i == m - 1) && (j == n - 1);
                     pending.push_back(p);
                  end
               end
            end
            default: begin
            end
         endcase
      endfunction

      function void check_product(product_type got);
         product_type want;
         checked++;
         if (got.sat) begin
            saturations++;
         end
         if (pending.size() == 0) begin
            errors++;
            $display("%0t: unexpected product beat: expected none, actual row %0d col %0d value %0d",
                     $time, got.row, got.col, got.value);
            return;
         end
         want = pending.pop_front();
         if (got.value !== want.value) begin
            errors++;
            $display("%0t: product_value at (%0d,%0d): expected %0d actual %0d",
                     $time, want.row, want.col, want.value, got.value);
         end
         if (got.row !== want.row) begin
            errors++;
            $display("%0t: product_row: expected %0d actual %0d", $time, want.row, got.row);
         end
         if (got.col !== want.col) begin
            errors++;
            $display("%0t: product_col: expected %0d actual %0d", $time, want.col, got.col);
         end
         if (got.sat !== want.sat) begin
            errors++;
            $display("%0t: saturated at (%0d,%0d): expected %0b actual %0b",
                     $time, want.row, want.col, want.sat, got.sat);
         end
         if (got.last !== want.last) begin
            errors++;
            $display("%0t: last_of_run at (%0d,%0d): expected %0b actual %0b",
                     $time, want.row, want.col, want.last, got.last);
         end
      endfunction
   endclass

   logic clock;
   logic reset;

   mme_req_if req_bus ();
   mme_rsp_if rsp_bus ();
   mme_csr_if csr_bus ();

   product_tracker_type board;
   product_type         got_beat;
   bit                  calm;
   int                  random_items;
   int                  size_settings;
   int                  quiet_cycles;
   int                  stall_left;

   matrix_multiply_engine i_dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_bus),
      .rsp_if (rsp_bus),
      .csr_if (csr_bus)
   );

   always #5 clock = ~clock;

   // Product sink: checks each accepted beat and throttles ready in bursts.
   always @(posedge clock) begin
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         got_beat.value = rsp_bus.product_value;
         got_beat.row   = rsp_bus.product_row;
         got_beat.col   = rsp_bus.product_col;
         got_beat.sat   = rsp_bus.saturated;
         got_beat.last  = rsp_bus.last_of_run;
         board.check_product(got_beat);
      end
      if (stall_left > 0) begin
         stall_left--;
         rsp_bus.ready <= 1'b0;
      end else if (!calm && $urandom_range(0, 7) == 0) begin
         stall_left = $urandom_range(1, 14) - 1;
         rsp_bus.ready <= 1'b0;
      end else begin
         rsp_bus.ready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready) ||
          (csr_bus.valid && csr_bus.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("%0t: no beat on any channel for %0d cycles", $time, quiet_cycles);
         $display("FAILED: results differ");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   function automatic logic signed [DATA_W-1:0] rand_element();
      case ($urandom_range(0, 5))
         0: return 16'sh7FFF;
         1: return 16'sh8000;
         2, 3: return 16'($signed($urandom_range(0, 1023)) - 512);
         default: return 16'($urandom);
      endcase
   endfunction

   function automatic logic [DIM_W-1:0] pick_size();
      case ($urandom_range(0, 9))
         0: return '0;
         1: return 4'd15;
         2: return 4'd8;
         3: return DIM_W'($urandom_range(9, 15));
         default: return DIM_W'($urandom_range(1, 4));
      endcase
   endfunction

   // Valid is left high after a beat so that a following item goes out back to back.
   task automatic send_item(logic [OPC_W-1:0] opcode, logic [ADDR_W-1:0] index,
                            logic signed [DATA_W-1:0] value);
      if (!calm && $urandom_range(0, 4) == 0) begin
         req_bus.valid <= 1'b0;
         repeat ($urandom_range(1, 14)) @(posedge clock);
      end
      req_bus.valid         <= 1'b1;
      req_bus.opcode        <= opcode;
      req_bus.element_index <= index;
      req_bus.element_value <= value;
      do @(posedge clock); while (!req_bus.ready);
      board.note_request(opcode, index, value);
      if (opcode != OP_NONE) begin
         random_items++;
      end
   endtask

   task automatic write_csr(logic [CSR_IDX_W-1:0] index, logic [DIM_W-1:0] data);
      csr_bus.valid <= 1'b1;
      csr_bus.index <= index;
      csr_bus.data  <= data;
      do @(posedge clock); while (!csr_bus.ready);
      board.write_size(index, data);
   endtask

   task automatic set_sizes(logic [DIM_W-1:0] rows, logic [DIM_W-1:0] cols,
                            logic [DIM_W-1:0] inner);
      write_csr(REG_ROW_COUNT, rows);
      write_csr(REG_COL_COUNT, cols);
      write_csr(REG_INNER_COUNT, inner);
      if ($urandom_range(0, 3) == 0) begin
         write_csr(REG_UNUSED, 4'($urandom));
      end
      csr_bus.valid <= 1'b0;
      size_settings++;
   endtask

   task automatic wait_idle();
      req_bus.valid <= 1'b0;
      while (board.pending.size() != 0) @(posedge clock);
      repeat (IDLE_GUARD) @(posedge clock);
   endtask

   // A compute may only read entries that were loaded, so fill any gaps first.
   task automatic load_missing_operands();
      int m;
      int n;
      int k;
      m = board.used_dim(REG_ROW_COUNT);
      n = board.used_dim(REG_COL_COUNT);
      k = board.used_dim(REG_INNER_COUNT);
      for (int i = 0; i < m * k; i++) begin
         if (!board.written_a[i]) begin
            send_item(OP_LOAD_A, ADDR_W'(i), rand_element());
         end
      end
      for (int i = 0; i < k * n; i++) begin
         if (!board.written_b[i]) begin
            send_item(OP_LOAD_B, ADDR_W'(i), rand_element());
         end
      end
   endtask

   task automatic run_phase(int length);
      int m;
      int n;
      int k;
      int pick;
      m = board.used_dim(REG_ROW_COUNT);
      n = board.used_dim(REG_COL_COUNT);
      k = board.used_dim(REG_INNER_COUNT);
      for (int s = 0; s < length; s++) begin
         pick = $urandom_range(0, 99);
         if (pick < 30) begin
            send_item(OP_LOAD_A, ADDR_W'($urandom_range(0, m * k - 1)), rand_element());
         end else if (pick < 55) begin
            send_item(OP_LOAD_B, ADDR_W'($urandom_range(0, k * n - 1)), rand_element());
         end else if (pick < 65) begin
            // Anywhere in the store, including beyond the current matrix.
            send_item(pick[0] ? OP_LOAD_A : OP_LOAD_B, ADDR_W'($urandom), rand_element());
         end else if (pick < 72) begin
            send_item(OP_NONE, ADDR_W'($urandom), DATA_W'($urandom));
         end else if (pick < 75) begin
            req_bus.valid <= 1'b0;
            do @(posedge clock); while (board.pending.size() != 0);
         end else begin
            load_missing_operands();
            send_item(OP_COMPUTE, ADDR_W'($urandom), DATA_W'($urandom));
         end
      end
   endtask

   initial begin
      clock                 = 1'b0;
      reset                 = 1'b1;
      req_bus.valid         = 1'b0;
      req_bus.opcode        = OP_LOAD_A;
      req_bus.element_index = '0;
      req_bus.element_value = '0;
      rsp_bus.ready         = 1'b0;
      csr_bus.valid         = 1'b0;
      csr_bus.index         = REG_ROW_COUNT;
      csr_bus.data          = '0;
      calm                  = 1'b0;
      stall_left            = 0;
      quiet_cycles          = 0;
      random_items          = 0;
      size_settings         = 0;
      board                 = new();
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Single-element products: both saturation directions, flooring and plain values.
      set_sizes(4'd1, 4'd1, 4'd1);
      send_item(OP_LOAD_A, 6'd0, 16'sh7FFF);
      send_item(OP_LOAD_B, 6'd0, 16'sh7FFF);
      send_item(OP_COMPUTE, 6'd0, 16'sh0000);
      send_item(OP_LOAD_A, 6'd0, 16'sh8000);
      send_item(OP_COMPUTE, 6'd0, 16'sh0000);
      send_item(OP_LOAD_B, 6'd0, 16'sh8000);
      send_item(OP_COMPUTE, 6'd0, 16'sh0000);
      send_item(OP_LOAD_A, 6'd0, 16'shFFFF);
      send_item(OP_LOAD_B, 6'd0, 16'sh0001);
      send_item(OP_COMPUTE, 6'd0, 16'sh0000);
      send_item(OP_LOAD_A, 6'd0, 16'sh0001);
      send_item(OP_COMPUTE, 6'd0, 16'sh0000);
      send_item(OP_LOAD_A, 6'd0, 16'sh0100);
      send_item(OP_LOAD_B, 6'd0, 16'sh0180);
      send_item(OP_COMPUTE, 6'd0, 16'sh0000);
      send_item(OP_NONE, 6'd63, 16'sh8000);
      send_item(OP_LOAD_A, 6'd63, 16'sh7FFF);
      send_item(OP_LOAD_B, 6'd63, 16'sh0000);
      send_item(OP_COMPUTE, 6'd63, 16'shFFFF);
      send_item(OP_LOAD_A, 6'd42, 16'sh5555);
      send_item(OP_LOAD_B, 6'd21, 16'shAAAA);
      wait_idle();

      random_items = 0;
      set_sizes(4'd8, 4'd8, 4'd8);
      run_phase(40);
      while (random_items < RANDOM_ITEMS) begin
         wait_idle();
         if (random_items > RANDOM_ITEMS - 50) begin
            calm = 1'b1;
         end
         set_sizes(pick_size(), pick_size(), pick_size());
         run_phase($urandom_range(15, 40));
      end
      wait_idle();

      $display("Covered %0d loads and %0d computes over %0d size settings,",
               board.loads, board.computes, size_settings);
      $display("checking %0d product elements, %0d of them saturated.",
               board.checked, board.saturations);
      if (board.errors == 0 && board.pending.size() == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

endmodule

// ===== matrix_multiply_engine.f =====
rtl/mme_pkg.sv
rtl/mme_if.sv
rtl/mme_ctrl.sv
rtl/mme_datapath.sv
rtl/matrix_multiply_engine.sv
tb/matrix_multiply_engine_tb.sv
